@@ design/tscrc_pkg.sv @@
`timescale 1ns / 1ps

package tscrc_pkg;

   localparam int CrcWidth  = 32;
   localparam int ByteWidth = 8;
   localparam int WordBytes = CrcWidth / ByteWidth;

   typedef logic [CrcWidth-1:0]  crc_type;
   typedef logic [ByteWidth-1:0] byte_type;

   localparam crc_type CRC_POLY   = 32'hEDB8_8320;
   localparam crc_type CRC_PRESET = 32'hFFFF_FFFF;
   localparam crc_type END_TOKEN  = 32'h0000_FFFF;

endpackage

@@ design/tscrc_byte_step.sv @@
`timescale 1ns / 1ps

module tscrc_byte_step (
   input  tscrc_pkg::crc_type  crc_i,
   input  tscrc_pkg::byte_type data_i,
   output tscrc_pkg::crc_type  crc_o
);

   always_comb begin
      tscrc_pkg::crc_type c;
      c = crc_i ^ {{(tscrc_pkg::CrcWidth - tscrc_pkg::ByteWidth){1'b0}}, data_i};
      // reflected form, one bit per step
      for (int b = 0; b < tscrc_pkg::ByteWidth; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ tscrc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_o = c;
   end

endmodule

@@ design/tscrc_word_fold.sv @@
`timescale 1ns / 1ps

module tscrc_word_fold (
   input  tscrc_pkg::crc_type crc_i,
   input  tscrc_pkg::crc_type word_i,
   output tscrc_pkg::crc_type crc_o
);

   tscrc_pkg::crc_type chain [0:tscrc_pkg::WordBytes];

   assign chain[0] = crc_i;

   // low byte first
   for (genvar k = 0; k < tscrc_pkg::WordBytes; k++) begin : g_byte
      tscrc_byte_step u_step (
         .crc_i  (chain[k]),
         .data_i (word_i[k*tscrc_pkg::ByteWidth +: tscrc_pkg::ByteWidth]),
         .crc_o  (chain[k+1])
      );
   end

   assign crc_o = chain[tscrc_pkg::WordBytes];

endmodule

@@ design/token_stream_crc32.sv @@
`timescale 1ns / 1ps

// Running reflected CRC-32 over a stream of 32-bit program words.
// Input channel req_ carries one code word per item; every word is folded
// into the CRC as four bytes, low byte first. The end token 0x0000FFFF is
// folded in as well and then causes one item on the rsp_ channel: the
// complemented CRC as the program hash. The CRC then presets to all ones.
// An end token waits in the input register; its hash is then registered in
// the result register, which drives rsp_valid.
// Throughput: one word per clock while no end token stalls; the four byte
// steps of a word are combinational from input register to CRC register.
// Stalls: a held result does not block ordinary words. Only an end token
// waits in the input register while the previous hash is still unread,
// and req_ready drops behind it until rsp_ready frees the result register.
// Reset (synchronous, active high) empties both registers and presets the
// CRC to all ones.

module token_stream_crc32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_code_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_program_hash
);

   logic               stage_valid_ff, stage_valid_in;
   tscrc_pkg::crc_type stage_word_ff,  stage_word_in;
   tscrc_pkg::crc_type crc_ff,         crc_in;
   logic               out_valid_ff,   out_valid_in;
   tscrc_pkg::crc_type out_hash_ff,    out_hash_in;

   tscrc_pkg::crc_type folded;
   logic               is_end;
   logic               out_free;
   logic               stage_fire;
   logic               req_fire;

   tscrc_word_fold u_fold (
      .crc_i  (crc_ff),
      .word_i (stage_word_ff),
      .crc_o  (folded)
   );

   assign is_end     = (stage_word_ff == tscrc_pkg::END_TOKEN);
   assign out_free   = !out_valid_ff || rsp_ready;
   // only an end token needs room in the result register
   assign stage_fire = stage_valid_ff && (!is_end || out_free);
   assign req_ready  = !stage_valid_ff || stage_fire;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_word_in  = stage_word_ff;
      crc_in         = crc_ff;
      out_valid_in   = out_valid_ff;
      out_hash_in    = out_hash_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (stage_fire) begin
         stage_valid_in = 1'b0;
         if (is_end) begin
            crc_in       = tscrc_pkg::CRC_PRESET;
            out_valid_in = 1'b1;
            out_hash_in  = ~folded;
         end else begin
            crc_in = folded;
         end
      end

      if (req_fire) begin
         stage_valid_in = 1'b1;
         stage_word_in  = req_code_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         crc_ff         <= tscrc_pkg::CRC_PRESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         crc_ff         <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_word_ff <= stage_word_in;
      out_hash_ff   <= out_hash_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_program_hash = out_hash_ff;

endmodule

@@ test/program_hash_checker.sv @@
`timescale 1ns / 1ps

module program_hash_checker
   import tscrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  crc_type req_code_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  crc_type rsp_program_hash,
   output int      error_count,
   output int      hashes_pending
);

   crc_type running_crc;
   crc_type expected_hashes[$];

   // reflected crc-32, four bytes per word, low byte first
   function automatic crc_type fold_code_word(crc_type crc, crc_type word);
      crc_type next_crc;
      next_crc = crc;
      for (int b = 0; b < WordBytes; b++) begin
         next_crc ^= crc_type'(word[b*ByteWidth +: ByteWidth]);
         for (int k = 0; k < ByteWidth; k++) begin
            next_crc = next_crc[0] ? ((next_crc >> 1) ^ CRC_POLY) : (next_crc >> 1);
         end
      end
      return next_crc;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   initial begin
      error_count    = 0;
      hashes_pending = 0;
      running_crc    = CRC_PRESET;
   end

   always @(posedge clock) begin
      crc_type want;
      if (reset) begin
         running_crc = CRC_PRESET;
         expected_hashes.delete();
      end else begin
         if (req_valid && req_ready) begin
            running_crc = fold_code_word(running_crc, req_code_word);
            if (req_code_word == END_TOKEN) begin
               expected_hashes = {expected_hashes, ~running_crc};
               running_crc = CRC_PRESET;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch($sformatf("hash %08h with no end token waiting",
                                         rsp_program_hash));
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_program_hash !== want) begin
                  report_mismatch($sformatf("program_hash %08h, want %08h",
                                            rsp_program_hash, want));
               end
            end
         end
      end
      hashes_pending = expected_hashes.size();
   end

endmodule

@@ test/token_stream_crc32_test.sv @@
`timescale 1ns / 1ps

module token_stream_crc32_test;
   import tscrc_pkg::*;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_ready;
   crc_type req_code_word    = '0;
   logic    rsp_valid;
   logic    rsp_ready        = 1'b0;
   crc_type rsp_program_hash;

   int error_count;
   int hashes_pending;
   int words_sent  = 0;
   bit steady_flow = 1'b0;

   token_stream_crc32 i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_word    (req_code_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_program_hash (rsp_program_hash)
   );

   program_hash_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_word    (req_code_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_program_hash (rsp_program_hash),
      .error_count      (error_count),
      .hashes_pending   (hashes_pending)
   );

   always #1 clock = ~clock;

   // hash reader stalls at random except during the steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 36);
   end

   task automatic send_word(input crc_type word);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_code_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // mostly random content, some words one bit away from the end token, the rest all zeros or all ones
   function automatic crc_type program_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85) return crc_type'($urandom);
      if (pick < 95) return END_TOKEN ^ (crc_type'(1) << $urandom_range(CrcWidth-1));
      return (pick < 97) ? '0 : '1;
   endfunction

   initial begin
      int body_len;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // end token straight after reset, then straight after a preset
      send_word(END_TOKEN);
      send_word(END_TOKEN);
      send_word(32'h0000_0000);
      send_word(END_TOKEN);
      send_word(32'hFFFF_FFFF);
      send_word(END_TOKEN);
      send_word(32'hAAAA_AAAA);
      send_word(32'h5555_5555);
      send_word(END_TOKEN);
      // near misses of the end token are plain words
      send_word(32'h0000_FFFE);
      send_word(32'h0001_FFFF);
      send_word(32'hFFFF_0000);
      send_word(32'h8000_FFFF);
      send_word(END_TOKEN);
      send_word(32'h8000_0000);
      send_word(32'h0000_0001);
      send_word(32'h1234_5678);
      send_word(END_TOKEN);

      while (words_sent < 1900) begin
         steady_flow = (words_sent >= 800 && words_sent < 1100);
         body_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
         repeat (body_len) send_word(program_word());
         // now and then a program runs on into the next one
         if ($urandom_range(19) != 0) send_word(END_TOKEN);
      end
      steady_flow = 1'b0;
      send_word(END_TOKEN);
      @(negedge clock);
      req_valid <= 1'b0;

      while (hashes_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0 && hashes_pending == 0) begin
         $display("token_stream_crc32 regression: pass");
      end else begin
         $display("token_stream_crc32 regression: fail");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("token_stream_crc32 regression: fail");
      $finish;
   end

endmodule
